// ===== design/swmf_pkg.sv =====
// Shared constants and types for the sliding window max filter.
package swmf_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int SAMPLE_W       = 32;
  localparam int POS_W          = 32;
  localparam int WSIZE_W        = 7;
  localparam int APB_ADDR_W     = 2;
  localparam int APB_DATA_W     = 32;

  localparam logic [WSIZE_W-1:0]    WSIZE_RESET        = 7'd3;
  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_SIZE   = 2'd0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] window_max;
    logic                       last_result;
  } result_t;

endpackage

// ===== design/swmf_if.sv =====
// Valid/ready stream interfaces for samples and window results.
interface swmf_in_if import swmf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       end_of_sequence;

  modport source (output valid, sample, end_of_sequence, input ready);
  modport sink   (input valid, sample, end_of_sequence, output ready);
endinterface

interface swmf_out_if import swmf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] window_max;
  logic                       last_result;

  modport source (output valid, window_max, last_result, input ready);
  modport sink   (input valid, window_max, last_result, output ready);
endinterface

// ===== design/swmf_cfg.sv =====
// APB register block holding the window size.
module swmf_cfg import swmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [WSIZE_W-1:0]    window_size
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_RESET;
    end else if (wr_en) begin
      window_size <= pwdata[WSIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_WINDOW_SIZE) begin
      prdata = {{(APB_DATA_W-WSIZE_W){1'b0}}, window_size};
    end
  end

endmodule

// ===== design/swmf_core.sv =====
// Monotonic queue sequencer over a one-port-read, one-port-write queue memory.
module swmf_core import swmf_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  swmf_in_if.sink            din,
  input  logic [WSIZE_W-1:0] window_size,
  input  logic               out_free,
  output logic               res_load,
  output result_t            res
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam logic [AW:0] DEPTH = (AW+1)'(WINDOW_MAX);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FRONT  = 3'd1;
  localparam logic [2:0] S_BACK   = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  // Each entry holds {value, position}.
  logic [SAMPLE_W+POS_W-1:0] mem [WINDOW_MAX];
  logic [SAMPLE_W+POS_W-1:0] rd_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;

  logic [2:0]                 state;
  logic [AW-1:0]              head;
  logic [CW-1:0]              count;
  logic [POS_W-1:0]           pos;
  logic                       filled;
  logic signed [SAMPLE_W-1:0] x;
  logic                       last;
  logic [WSIZE_W-1:0]         k;
  logic signed [SAMPLE_W-1:0] front_val;
  result_t                    res_q;

  logic [WSIZE_W-1:0]         k_eff;
  logic signed [SAMPLE_W-1:0] rd_val;
  logic [POS_W-1:0]           age;
  logic                       front_evict;
  logic                       back_evict;
  logic                       reached;
  logic                       produce;
  logic [AW-1:0]              head_inc;
  logic                       accept;
  result_t                    res_now;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= DEPTH) begin
      sum = sum - DEPTH;
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    if (window_size == '0) begin
      k_eff = WSIZE_W'(1);
    end else if ({{(32-WSIZE_W){1'b0}}, window_size} > 32'(WINDOW_MAX)) begin
      k_eff = WSIZE_W'(WINDOW_MAX);
    end else begin
      k_eff = window_size;
    end
  end

  assign din.ready   = (state == S_IDLE);
  assign accept      = din.valid && din.ready;
  assign rd_val      = rd_data[SAMPLE_W+POS_W-1:POS_W];
  assign age         = pos - rd_data[POS_W-1:0];
  assign front_evict = (age >= POS_W'(k));
  assign back_evict  = (rd_val < x);
  assign reached     = (pos >= (POS_W'(k) - POS_W'(1)));
  assign produce     = filled || reached;
  assign head_inc    = wrap_add(head, AW'(1));
  assign wr_addr     = wrap_add(head, AW'(count));

  assign res_now.window_max  = (count == '0) ? x : front_val;
  assign res_now.last_result = last;

  assign res_load = ((state == S_APPEND) && produce && out_free) ||
                    ((state == S_EMIT) && out_free);
  assign res      = (state == S_APPEND) ? res_now : res_q;

  // Read address: front entry while aging out, tail entry while comparing.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    case (state)
      S_IDLE: begin
        rd_en = accept && (count != '0);
      end
      S_FRONT: begin
        if (front_evict) begin
          rd_en   = (count > CW'(1));
          rd_addr = head_inc;
        end else begin
          rd_en   = 1'b1;
          rd_addr = wrap_add(head, AW'(count - CW'(1)));
        end
      end
      S_BACK: begin
        rd_en   = back_evict && (count > CW'(1));
        rd_addr = wrap_add(head, AW'(count - CW'(2)));
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (state == S_APPEND) begin
      mem[wr_addr] <= {x, pos};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      count  <= '0;
      pos    <= '0;
      filled <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (count != '0) ? S_FRONT : S_APPEND;
          end
        end
        S_FRONT: begin
          if (front_evict) begin
            head  <= head_inc;
            count <= count - CW'(1);
            state <= (count > CW'(1)) ? S_FRONT : S_APPEND;
          end else begin
            state <= S_BACK;
          end
        end
        S_BACK: begin
          if (back_evict) begin
            count <= count - CW'(1);
            state <= (count > CW'(1)) ? S_BACK : S_APPEND;
          end else begin
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          if (last) begin
            head   <= '0;
            count  <= '0;
            pos    <= '0;
            filled <= 1'b0;
          end else begin
            count  <= count + CW'(1);
            pos    <= pos + POS_W'(1);
            filled <= produce;
          end
          state <= (produce && !out_free) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the sample and the result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      x    <= din.sample;
      last <= din.end_of_sequence;
      k    <= k_eff;
    end
    if ((state == S_FRONT) && !front_evict) begin
      front_val <= rd_val;
    end
    if (state == S_APPEND) begin
      res_q <= res_now;
    end
  end

endmodule

// ===== design/sliding_window_max_filter_top.sv =====
// Sliding window max filter: streams samples in, window maxima out.
//
// din carries one signed sample and an end_of_sequence flag per transfer;
// dout carries window_max and last_result. psel/penable/pwrite/paddr/pwdata
// write window_size at address 0 (reset value 3, zero acts as 1, values
// above WINDOW_MAX act as WINDOW_MAX); prdata reads it back.
// A sample gives a result once window_size samples of its sequence have
// arrived; a sequence shorter than the window gives none. end_of_sequence
// is copied to last_result and empties the queue for the next sequence.
// One sample is in work at a time: after the transfer the sequencer ages out
// queue entries at the front one at a time, checks the front entry, compares
// entries at the tail one at a time, and appends the sample; an empty queue
// goes straight to the append. The single read port of the queue memory
// makes these steps serial. The result is loaded into the output register
// at the append when that register is free.
// A stalled receiver leaves the result in the output register; a following
// result waits in the sequencer, which takes no new sample until it moves.
// Reset empties the queue, clears the position counter and the output valid.
module sliding_window_max_filter_top import swmf_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  swmf_in_if.sink               din,
  swmf_out_if.source            dout,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [WSIZE_W-1:0] window_size;
  logic               out_free;
  logic               res_load;
  result_t            res;
  logic               out_valid;
  result_t            out_q;

  swmf_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .window_size (window_size)
  );

  swmf_core #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .din         (din),
    .window_size (window_size),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res)
  );

  assign out_free = !out_valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign dout.valid       = out_valid;
  assign dout.window_max  = out_q.window_max;
  assign dout.last_result = out_q.last_result;

endmodule

// ===== design/swmf_checker.sv =====
// Port-level checks for the sliding window max filter, bound to the top level.
module swmf_checker import swmf_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       din_valid,
  input logic                       din_ready,
  input logic                       dout_valid,
  input logic                       dout_ready,
  input logic signed [SAMPLE_W-1:0] window_max,
  input logic                       last_result,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic                       pready,
  input logic [APB_ADDR_W-1:0]      paddr,
  input logic [APB_DATA_W-1:0]      pwdata,
  input logic [APB_DATA_W-1:0]      prdata
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !dout_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    dout_valid && !dout_ready |=>
      dout_valid && $stable(window_max) && $stable(last_result))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    din_valid && din_ready |=> !din_ready)
    else $error("second sample taken while one is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(dout_valid) |-> !$past(din_ready))
    else $error("result appeared with no sample in work");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_SIZE) |=>
      (paddr != ADDR_WINDOW_SIZE) || (prdata[WSIZE_W-1:0] == $past(pwdata[WSIZE_W-1:0])))
    else $error("window size readback mismatch");

endmodule

bind sliding_window_max_filter_top swmf_checker u_swmf_checker (
  .clk         (clk),
  .rst         (rst),
  .din_valid   (din.valid),
  .din_ready   (din.ready),
  .dout_valid  (dout.valid),
  .dout_ready  (dout.ready),
  .window_max  (dout.window_max),
  .last_result (dout.last_result),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .pready      (pready),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

// ===== tb/sliding_window_max_filter_top_tb.sv =====
// Self-checking testbench for the sliding window max filter top level.
`timescale 1ns / 100ps

module sliding_window_max_filter_top_tb;
  import swmf_pkg::*;

  localparam int DRAIN_CYCLES   = 2 * WINDOW_MAX_DEF + 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       eos;
  } sample_item_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  swmf_in_if  din_bus ();
  swmf_out_if dout_bus ();

  sliding_window_max_filter_top dut (
    .clk     (clk),
    .rst     (rst),
    .din     (din_bus.sink),
    .dout    (dout_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_item_t pending_samples[$];
  sample_item_t next_sample;
  result_t      expected_maxima[$];
  result_t      oldest_max;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  int hold_left;
  int mismatch_count;
  int quiet_cycles;

  // Predictor state: monotonic queue of (value, position) pairs.
  logic signed [SAMPLE_W-1:0] dq_value[WINDOW_MAX_DEF];
  logic [POS_W-1:0]           dq_position[WINDOW_MAX_DEF];
  logic [5:0]                 dq_head;
  int                         dq_count;
  logic [POS_W-1:0]           seq_position;
  bit                         window_full;
  logic [WSIZE_W-1:0]         win_size;

  function automatic logic [5:0] slot_at(int offset);
    return 6'(dq_head + offset);
  endfunction

  function automatic void clear_deque();
    dq_head      = '0;
    dq_count     = 0;
    seq_position = '0;
    window_full  = 1'b0;
  endfunction

  function automatic void predict_window_max(logic signed [SAMPLE_W-1:0] x, logic eos);
    logic [POS_W-1:0] k;
    logic [POS_W-1:0] pos;
    result_t          res;
    k = (win_size == 0) ? 1 : ((win_size > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : win_size);
    pos = seq_position;
    // drop entries that have aged out of the window
    while (dq_count > 0 && (pos - dq_position[slot_at(0)]) >= k) begin
      dq_head  = slot_at(1);
      dq_count = dq_count - 1;
    end
    // drop smaller entries at the tail; equal ones stay ahead
    while (dq_count > 0 && dq_value[slot_at(dq_count - 1)] < x)
      dq_count = dq_count - 1;
    if (dq_count < WINDOW_MAX_DEF) begin
      dq_value[slot_at(dq_count)]    = x;
      dq_position[slot_at(dq_count)] = pos;
      dq_count = dq_count + 1;
    end
    if (pos >= k - 1)
      window_full = 1'b1;
    if (window_full) begin
      res.window_max  = dq_value[slot_at(0)];
      res.last_result = eos;
      expected_maxima.insert(expected_maxima.size(), res);
    end
    seq_position = pos + 1;
    if (eos)
      clear_deque();
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  // Sample driver: hold valid until the transfer, then take the next item.
  always @(posedge clk) begin
    if (rst) begin
      din_bus.valid <= 1'b0;
    end else if (!din_bus.valid || din_bus.ready) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_sample = pending_samples[0];
        pending_samples.delete(0);
        din_bus.valid           <= 1'b1;
        din_bus.sample          <= next_sample.sample;
        din_bus.end_of_sequence <= next_sample.eos;
      end else begin
        din_bus.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      dout_bus.ready <= 1'b0;
      hold_left      <= 0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left      <= LONG_HOLD;
      dout_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      dout_bus.ready <= 1'b0;
    end else begin
      dout_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: track register writes, predict on sample transfers, check results.
  always @(posedge clk) begin
    if (rst) begin
      clear_deque();
      win_size = WSIZE_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_WINDOW_SIZE)
        win_size = pwdata[WSIZE_W-1:0];
      if (din_bus.valid && din_bus.ready)
        predict_window_max(din_bus.sample, din_bus.end_of_sequence);
      if (dout_bus.valid && dout_bus.ready) begin
        if (expected_maxima.size() == 0) begin
          report_mismatch($sformatf("unexpected result window_max=%0d last=%0b",
                                    dout_bus.window_max, dout_bus.last_result));
        end else begin
          oldest_max = expected_maxima[0];
          expected_maxima.delete(0);
          if (dout_bus.window_max !== oldest_max.window_max)
            report_mismatch($sformatf("window_max got %0d want %0d",
                                      dout_bus.window_max, oldest_max.window_max));
          if (dout_bus.last_result !== oldest_max.last_result)
            report_mismatch($sformatf("last_result got %0b want %0b",
                                      dout_bus.last_result, oldest_max.last_result));
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (din_bus.valid && din_bus.ready) || (dout_bus.valid && dout_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(logic signed [SAMPLE_W-1:0] value, logic eos);
    sample_item_t item;
    item.sample = value;
    item.eos    = eos;
    pending_samples.insert(pending_samples.size(), item);
  endtask

  task automatic wait_for_idle();
    while (pending_samples.size() != 0 || din_bus.valid || expected_maxima.size() != 0)
      @(negedge clk);
    // a sample with no result may still be in work
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_window_size(logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WINDOW_SIZE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly whole sequences of varied shape; some end short of the window.
  task automatic queue_random_samples(int n, int k);
    int                         len;
    int                         shape;
    logic signed [SAMPLE_W-1:0] v;
    while (n > 0) begin
      if ($urandom_range(7) == 0)
        len = $urandom_range(k, 1);
      else
        len = $urandom_range(3 * k + 6, k);
      shape = $urandom_range(4);
      v = $urandom;
      for (int i = 0; i < len && n > 0; i++) begin
        case (shape)
          0: v = $urandom;
          1: v = $urandom_range(16) - 8;
          2: v = v - $urandom_range(3);
          3: v = v + $urandom_range(3);
          default: begin
            case ($urandom_range(3))
              0: v = 32'h7FFF_FFFF;
              1: v = 32'h8000_0000;
              2: v = 0;
              default: v = -1;
            endcase
          end
        endcase
        push_sample(v, i == len - 1);
        n--;
      end
    end
  endtask

  task automatic run_phase(int win, int send_pct, int recv_pct, int n, bit long_hold);
    int k;
    wait_for_idle();
    write_window_size(win);
    k = (win == 0) ? 1 : ((win > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : win);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random_samples(n, k);
    if (long_hold) begin
      repeat (20) @(negedge clk);
      hold_request = 1'b1;
    end
  endtask

  initial begin
    rst                     = 1'b1;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    din_bus.valid           = 1'b0;
    din_bus.sample          = '0;
    din_bus.end_of_sequence = 1'b0;
    dout_bus.ready          = 1'b0;
    send_idle_pct           = 0;
    recv_stall_pct          = 0;
    hold_request            = 1'b0;
    mismatch_count          = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, at the reset window of three: extremes, short sequences, ties.
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(1, 1'b1);
    push_sample(7, 1'b0);
    push_sample(9, 1'b1);
    push_sample(-5, 1'b1);
    push_sample(5, 1'b0);
    push_sample(5, 1'b0);
    push_sample(5, 1'b0);
    push_sample(4, 1'b0);
    push_sample(5, 1'b0);
    push_sample(5, 1'b1);
    push_sample(100, 1'b0);
    push_sample(50, 1'b0);
    push_sample(20, 1'b0);
    push_sample(10, 1'b0);
    push_sample(-10, 1'b0);
    push_sample(-40, 1'b1);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h8000_0000, 1'b1);

    // Phase ends can fall mid-sequence, so a write can also resize a live window.
    run_phase(0, 0, 0, 150, 1'b0);
    run_phase(1, 84, 0, 150, 1'b0);
    run_phase(2, 0, 84, 150, 1'b0);
    run_phase(5, 7, 7, 200, 1'b0);
    run_phase(127, 0, 0, 250, 1'b0);
    run_phase(65, 84, 0, 150, 1'b0);
    run_phase(3, 0, 0, 150, 1'b1);
    run_phase(64, 0, 84, 200, 1'b0);
    run_phase($urandom_range(127), 7, 7, 200, 1'b0);
    run_phase($urandom_range(127), 0, 0, 150, 1'b0);

    wait_for_idle();
    if (mismatch_count == 0 && expected_maxima.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
